// ===== sv/tdt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types and constants for the task delay tick table.
// ----------------------------------------------------------------------------
package tdt_pkg;

  // Default number of delay slots.
  localparam int NUM_SLOTS_DEF = 8;

  // Most release results reported individually for one tick.
  localparam int MAX_RESULTS = 8;

  // Field widths.
  localparam int TASK_W  = 8;
  localparam int TICKS_W = 16;
  localparam int COUNT_W = 7;

  // Input request codes.
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_DELAY = 1'b1;

  // Result kind codes.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  // One memory word: the task id and its remaining tick count.
  typedef struct packed {
    logic [TASK_W-1:0]  task_id;
    logic [TICKS_W-1:0] remaining;
  } slot_t;

  // One result item.
  typedef struct packed {
    logic               kind;
    logic               released_valid;
    logic [TASK_W-1:0]  released_task;
    logic [COUNT_W-1:0] release_count;
    logic               table_full;
    logic               last;
  } res_t;

endpackage

// ===== sv/tdt_req_if.sv =====
// ----------------------------------------------------------------------------
// tdt_req_if
// Input channel: a tick or a delay request, with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tdt_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [tdt_pkg::TASK_W-1:0]  task_id;
  logic [tdt_pkg::TICKS_W-1:0] delay_ticks;

  modport source (output valid, output req_type, output task_id, output delay_ticks,
                  input ready);
  modport sink   (input valid, input req_type, input task_id, input delay_ticks,
                  output ready);
endinterface

// ===== sv/tdt_res_if.sv =====
// ----------------------------------------------------------------------------
// tdt_res_if
// Result channel: release reports and request acknowledgments.
// ----------------------------------------------------------------------------
interface tdt_res_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic                        released_valid;
  logic [tdt_pkg::TASK_W-1:0]  released_task;
  logic [tdt_pkg::COUNT_W-1:0] release_count;
  logic                        table_full;
  logic                        last;

  modport source (output valid, output kind, output released_valid,
                  output released_task, output release_count, output table_full,
                  output last, input ready);
  modport sink   (input valid, input kind, input released_valid,
                  input released_task, input release_count, input table_full,
                  input last, output ready);
endinterface

// ===== sv/task_delay_tick_table.sv =====
// ----------------------------------------------------------------------------
// task_delay_tick_table
// Delay slot table for a tick-driven task scheduler.
// ----------------------------------------------------------------------------
// A delay request searches the used flags from slot 0 upward, one slot per
// cycle while the result register can take an item; a full table answers
// with table_full. A tick sweeps every slot through the slot memory, one slot
// per cycle while the result register can take an item, with a registered
// read ahead of each slot's update. Each expired slot gives one release
// transfer, in slot order, and the last transfer of a tick carries the
// release count; at most eight releases are reported one by one, the rest
// are only counted. One item is worked on at a time; the next is taken once
// the final result of the current one sits in the result register. A zero
// delay waits 65536 ticks. Reset clears the used flags at once, so the block
// is ready in the cycle after reset.
// ----------------------------------------------------------------------------
module task_delay_tick_table #(
  parameter int NUM_SLOTS = tdt_pkg::NUM_SLOTS_DEF
) (
  input logic       clk,
  input logic       rst,
  tdt_req_if.sink   req,
  tdt_res_if.source res
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  tdt_pkg::slot_t   mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  tdt_pkg::slot_t   mem_rd_data;

  // Sequencer and result register.
  tdt_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // Task ids and tick counts of all slots.
  tdt_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

// ===== sv/tdt_slot_mem.sv =====
// ----------------------------------------------------------------------------
// tdt_slot_mem
// Slot memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tdt_slot_mem #(
  parameter int NUM_SLOTS = tdt_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IDX_W-1:0]    wr_addr,
  input  tdt_pkg::slot_t      wr_data,
  input  logic                rd_en,
  input  logic [IDX_W-1:0]    rd_addr,
  output tdt_pkg::slot_t      rd_data
);

  tdt_pkg::slot_t mem [NUM_SLOTS];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/tdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdt_ctrl
// Sequencer: slot sweeps for ticks and free-slot search for requests, the
// used flags and the result register.
// ----------------------------------------------------------------------------
module tdt_ctrl #(
  parameter int NUM_SLOTS = tdt_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  tdt_req_if.sink          req,
  tdt_res_if.source        res,
  output logic             mem_wr_en,
  output logic [IDX_W-1:0] mem_wr_addr,
  output tdt_pkg::slot_t   mem_wr_data,
  output logic             mem_rd_en,
  output logic [IDX_W-1:0] mem_rd_addr,
  input  tdt_pkg::slot_t   mem_rd_data
);

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int RES_W = $clog2(tdt_pkg::MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REQ    = 4'b0010,
    ST_SWEEP  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                      state;
  logic [CNT_W-1:0]            idx;
  logic                        p_vld;
  logic [IDX_W-1:0]            p_idx;
  logic [NUM_SLOTS-1:0]        used;
  logic [CNT_W-1:0]            cnt;
  logic [RES_W-1:0]            n_res;
  logic                        pend_vld;
  logic [tdt_pkg::TASK_W-1:0]  pend_task;
  logic [tdt_pkg::TASK_W-1:0]  lat_task;
  logic [tdt_pkg::TICKS_W-1:0] lat_ticks;
  logic                        out_vld;
  tdt_pkg::res_t               out_res;

  logic                        ofree;
  logic                        issue;
  logic                        proc_slot;
  logic [tdt_pkg::TICKS_W-1:0] rem_next;
  logic                        rel;
  logic                        rel_report;
  logic                        req_free;
  logic                        req_last;
  logic                        emit;
  tdt_pkg::res_t               emit_res;

  // The result register can take a new item this cycle.
  assign ofree = !out_vld || res.ready;

  assign req.ready = (state == ST_IDLE);

  // Sweep datapath: read slot idx while the previously read slot is updated.
  assign issue      = (state == ST_SWEEP) && ofree && (idx < CNT_W'(NUM_SLOTS));
  assign proc_slot  = (state == ST_SWEEP) && ofree && p_vld && used[p_idx];
  assign rem_next   = mem_rd_data.remaining - 1'b1;
  assign rel        = proc_slot && (rem_next == '0);
  assign rel_report = rel && (n_res < RES_W'(tdt_pkg::MAX_RESULTS));

  // Free-slot search for a delay request, one slot per cycle while the result register can take an item.
  assign req_free = !used[idx[IDX_W-1:0]];
  assign req_last = (idx == CNT_W'(NUM_SLOTS - 1));

  assign mem_rd_en   = issue;
  assign mem_rd_addr = idx[IDX_W-1:0];

  // Memory write: place a request, or store a decremented count.
  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = p_idx;
    mem_wr_data = '{task_id: mem_rd_data.task_id, remaining: rem_next};
    if (state == ST_REQ && ofree && req_free) begin
      mem_wr_en   = 1'b1;
      mem_wr_addr = idx[IDX_W-1:0];
      mem_wr_data = '{task_id: lat_task, remaining: lat_ticks};
    end else if (proc_slot) begin
      mem_wr_en = 1'b1;
    end
  end

  // Result selection for this cycle.
  always_comb begin
    emit     = 1'b0;
    emit_res = '0;
    unique case (state)
      ST_REQ: begin
        if (ofree && (req_free || req_last)) begin
          emit              = 1'b1;
          emit_res.kind     = tdt_pkg::KIND_ACK;
          emit_res.table_full = !req_free;
          emit_res.last     = 1'b1;
        end
      end
      ST_SWEEP: begin
        // A new release pushes out the one held back, which is not the last.
        if (rel_report && pend_vld) begin
          emit                    = 1'b1;
          emit_res.kind           = tdt_pkg::KIND_TICK;
          emit_res.released_valid = 1'b1;
          emit_res.released_task  = pend_task;
        end
      end
      ST_FINISH: begin
        if (ofree) begin
          emit                   = 1'b1;
          emit_res.kind          = tdt_pkg::KIND_TICK;
          emit_res.last          = 1'b1;
          if (pend_vld) begin
            emit_res.released_valid = 1'b1;
            emit_res.released_task  = pend_task;
            emit_res.release_count  = tdt_pkg::COUNT_W'(cnt);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer state, counters and used flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      used     <= '0;
      p_vld    <= 1'b0;
      pend_vld <= 1'b0;
      idx      <= '0;
      cnt      <= '0;
      n_res    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            idx       <= '0;
            lat_task  <= req.task_id;
            lat_ticks <= req.delay_ticks;
            if (req.req_type == tdt_pkg::REQ_DELAY) begin
              state <= ST_REQ;
            end else begin
              p_vld    <= 1'b0;
              pend_vld <= 1'b0;
              cnt      <= '0;
              n_res    <= '0;
              state    <= ST_SWEEP;
            end
          end
        end
        ST_REQ: begin
          if (ofree) begin
            if (req_free) begin
              used[idx[IDX_W-1:0]] <= 1'b1;
              state                <= ST_IDLE;
            end else if (req_last) begin
              state <= ST_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_SWEEP: begin
          if (ofree) begin
            p_vld <= issue;
            if (issue) begin
              idx   <= idx + 1'b1;
              p_idx <= idx[IDX_W-1:0];
            end
            if (rel) begin
              used[p_idx] <= 1'b0;
              cnt         <= cnt + 1'b1;
            end
            if (rel_report) begin
              pend_vld  <= 1'b1;
              pend_task <= mem_rd_data.task_id;
              n_res     <= n_res + 1'b1;
            end
            if (!issue && !p_vld) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (ofree) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (emit) begin
      out_vld <= 1'b1;
    end else if (res.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res <= emit_res;
    end
  end

  assign res.valid          = out_vld;
  assign res.kind           = out_res.kind;
  assign res.released_valid = out_res.released_valid;
  assign res.released_task  = out_res.released_task;
  assign res.release_count  = out_res.release_count;
  assign res.table_full     = out_res.table_full;
  assign res.last           = out_res.last;

  // The sweep pipeline is empty whenever a new item may be taken.
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !p_vld)
    else $error("Sweep stage still holds a slot while idle.");

  // Every reported release is also counted.
  a_count_covers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP || state == ST_FINISH) |-> (CNT_W'(n_res) <= cnt))
    else $error("More release results than counted releases.");

  // A result that is not the last one is always a release report.
  a_mid_release: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !out_res.last) |->
      (out_res.kind == tdt_pkg::KIND_TICK && out_res.released_valid))
    else $error("Non-final result is not a release.");

  // A held-back release exists exactly when at least one was reported.
  a_pend_match: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP || state == ST_FINISH) |-> (pend_vld == (n_res != '0)))
    else $error("Held release does not match the report count.");

  // A released slot is no longer in use afterwards.
  a_release_frees: assert property (@(posedge clk) disable iff (rst)
    rel |=> !used[$past(p_idx)])
    else $error("Expired slot was not freed.");

endmodule
